[rtl/core/slid_pkg.sv]
package slid_pkg;

  localparam int CAPACITY = 64;
  localparam int CAP_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RD_GRP   = 8;
  localparam int RD_LSB   = $clog2(RD_GRP);
  localparam int RD_NGRP  = 64 / RD_GRP;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [5:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         position;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               empty_res;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic apply;
  } ctrl_cmd_t;

  function automatic logic [6:0] to_field7(input logic [CNT_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[6:0];
  endfunction

endpackage

[rtl/core/slid_ctrl.sv]
module slid_ctrl
  import slid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    out_free    = !out_valid_r || out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        // hold the update until the result register can take it
        cmd.apply = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.apply || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

  a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> (!out_valid_r || out_ready))
    else $error("update while result register busy");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready ##1 !in_ready)
    else $error("transaction accepted during evaluation");

  a_apply_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid_r)
    else $error("result lost after update");

endmodule

[rtl/core/slid_dp.sv]
module slid_dp
  import slid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  in_item_t           item_r;
  logic signed [31:0] entry_r [CAPACITY];
  logic signed [31:0] entry_nxt [CAPACITY];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAPACITY-1:0] m_r, m_nxt;   // entry at or above the insert point
  logic [CAPACITY-1:0] eq_r, eq_nxt;
  logic signed [31:0] grp_r [RD_NGRP];
  logic signed [31:0] grp_nxt [RD_NGRP];
  out_item_t          res_r, res_nxt;

  logic [CNT_W-1:0]   at;
  logic [CAP_W:0]     probe;
  logic               found;

  // compare every entry against the held value, first read tree level
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      m_nxt[i]  = (CNT_W'(i) >= count_r) || !(entry_r[i] < item_r.value);
      eq_nxt[i] = entry_r[i] == item_r.value;
    end
    for (int g = 0; g < RD_NGRP; g++) begin
      int addr;
      addr = g * RD_GRP + int'(item_r.read_index[RD_LSB-1:0]);
      if (addr < CAPACITY) grp_nxt[g] = entry_r[CAP_W'(addr)];
      else grp_nxt[g] = '0;
    end
  end

  // m_r is monotone, so a binary search finds the first set position
  always_comb begin
    at = '0;
    for (int b = CAP_W - 1; b >= 0; b--) begin
      probe = (CAP_W + 1)'(at) + (CAP_W + 1)'((1 << b) - 1);
      if (probe < (CAP_W + 1)'(CAPACITY)) begin
        if (!m_r[probe[CAP_W-1:0]]) at = at + CNT_W'(1 << b);
      end
    end
    if (!m_r[CAPACITY-1]) at = CNT_W'(CAPACITY);
    found = (at < count_r) && eq_r[at[CAP_W-1:0]];
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entry_nxt[i] = entry_r[i];
    count_nxt        = count_r;
    res_nxt          = '0;
    res_nxt.status   = ST_OK;
    case (item_r.command)
      CMD_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          res_nxt.status = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == at) entry_nxt[i] = item_r.value;
            else if (i > 0 && CNT_W'(i) > at) entry_nxt[i] = entry_r[i-1];
          end
          count_nxt        = count_r + CNT_W'(1);
          res_nxt.position = to_field7(at);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CNT_W'(i) >= at) entry_nxt[i] = entry_r[i+1];
          end
          count_nxt        = count_r - CNT_W'(1);
          res_nxt.position = to_field7(at);
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        res_nxt.position = {1'b0, item_r.read_index};
        if (CNT_W'(item_r.read_index) < count_r && int'(item_r.read_index) < CAPACITY) begin
          res_nxt.read_value = grp_r[item_r.read_index[5:RD_LSB]];
        end else begin
          res_nxt.status = ST_BAD_INDEX;
        end
      end
      default: ;
    endcase
    res_nxt.count     = to_field7(count_nxt);
    res_nxt.empty_res = count_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.eval) begin
      m_r  <= m_nxt;
      eq_r <= eq_nxt;
      for (int g = 0; g < RD_NGRP; g++) grp_r[g] <= grp_nxt[g];
    end
    if (cmd.apply) begin
      res_r <= res_nxt;
      for (int i = 0; i < CAPACITY; i++) entry_r[i] <= entry_nxt[i];
    end
  end

  assign out_data = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> res_r.empty_res == (count_r == '0))
    else $error("empty flag disagrees with count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && item_r.command == CMD_INSERT && count_r < CNT_W'(CAPACITY)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the store");

  a_delete_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && item_r.command == CMD_DELETE
    |=> (res_r.status == ST_NOT_FOUND) == (count_r == $past(count_r)))
    else $error("delete status disagrees with count");

endmodule

[rtl/core/sorted_list_insert_delete.sv]
// Sorted store of up to CAPACITY signed 32-bit values kept in ascending order in a
// register array. Insert places a value ahead of its first greater-or-equal entry
// (duplicates kept), delete removes the first equal entry, read returns the entry at
// a sorted position; every transaction gives exactly one result. The accepting edge
// captures the transaction into a register, the evaluation state registers the parallel
// compare of all entries (and the first read mux level), and the update state shifts the
// array and loads the result register, which makes the result valid. The next
// transaction is accepted only after that update, so transactions do not overlap; a
// result held in the output register stalls the following update.
module sorted_list_insert_delete
  import slid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;

  slid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  slid_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
